// ----- rtl/gic_pkg.sv -----
// Package for the gamepad input conditioner.
// Holds the sequencer state type, register indexes and fixed constants.
// No dependencies.
package gic_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEFT_DZ   = 3'd0;
    localparam logic [2:0] CFG_RIGHT_DZ  = 3'd1;
    localparam logic [2:0] CFG_STICK_MAX = 3'd2;
    localparam logic [2:0] CFG_TRIG_TH   = 3'd3;
    localparam logic [2:0] CFG_TRIG_MAX  = 3'd4;
    localparam logic [2:0] CFG_RETRY_MS  = 3'd5;

    // Register reset values.
    localparam logic [14:0] RST_LEFT_DZ   = 15'd7849;
    localparam logic [14:0] RST_RIGHT_DZ  = 15'd8689;
    localparam logic [14:0] RST_STICK_MAX = 15'd32762;
    localparam logic [7:0]  RST_TRIG_TH   = 8'd30;
    localparam logic [7:0]  RST_TRIG_MAX  = 8'd250;
    localparam logic [15:0] RST_RETRY_MS  = 16'd2000;

    localparam logic [14:0] FULL_SCALE = 15'h7FFF;
    localparam logic [17:0] TIMER_MIN  = 18'h20000;

    // Lanes 0..3 are the stick axes, 4 and 5 the triggers.
    localparam logic [2:0] LANE_LAST = 3'd5;
    localparam logic [3:0] DIV_LAST  = 4'd14;

endpackage

// ----- rtl/gamepad_input_conditioner_unit.sv -----
// Gamepad input conditioner: retry timer, button edges, stick and trigger scaling.
// A sampled item is accepted, then runs six lanes in turn through one
// shared restoring divider (setup, range check, 15 quotient steps), then goes to output;
// a lane that needs no division skips the quotient steps. Unsampled items skip the lanes.
// One item is in work at a time.
// Synchronous active-low reset restores defaults, clears sequencer, timer, held results.
module gamepad_input_conditioner_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_elapsed_ms,
    input  logic               i_read_ok,
    input  logic [15:0]        i_raw_buttons,
    input  logic signed [15:0] i_raw_left_x,
    input  logic signed [15:0] i_raw_left_y,
    input  logic signed [15:0] i_raw_right_x,
    input  logic signed [15:0] i_raw_right_y,
    input  logic [7:0]         i_raw_left_trigger,
    input  logic [7:0]         i_raw_right_trigger,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_sampled,
    output logic [15:0]        o_buttons_down,
    output logic [15:0]        o_buttons_pressed_edge,
    output logic [15:0]        o_buttons_released_edge,
    output logic signed [15:0] o_left_x,
    output logic signed [15:0] o_left_y,
    output logic signed [15:0] o_right_x,
    output logic signed [15:0] o_right_y,
    output logic [14:0]        o_left_trigger,
    output logic [14:0]        o_right_trigger
);

    // Configuration registers
    logic [14:0] r_left_dz, r_right_dz, r_stick_max;
    logic [7:0]  r_trig_th, r_trig_max;
    logic [15:0] r_retry_ms;

    // Architectural state
    gic_pkg::t_state r_state, n_state;
    logic [17:0] r_timer;
    logic [15:0] r_buttons, r_pressed, r_released;
    logic [15:0] r_axis [4];
    logic [14:0] r_trig [2];

    // Latched raw samples of the item in work
    logic [15:0] r_raw_axis [4];
    logic [7:0]  r_raw_trig [2];
    logic        r_sampled;

    // Lane sequencer and divider
    logic [2:0]  r_lane;
    logic [14:0] r_mag, r_den;
    logic        r_neg, r_zero, r_full;
    logic [14:0] r_rem, r_low;
    logic [3:0]  r_cnt;

    // Output register
    logic        r_out_valid, r_out_sampled;
    logic [15:0] r_out_buttons, r_out_pressed, r_out_released;
    logic [15:0] r_out_axis [4];
    logic [14:0] r_out_trig [2];

    // Timer decision at accept
    logic        s_sample;
    logic [18:0] s_tdec;
    logic [17:0] s_timer_dec;

    // Lane setup
    logic [15:0] s_raw, s_mag16, s_m16;
    logic [14:0] s_dz, s_axis_m;
    logic [7:0]  s_t, s_b;
    logic [14:0] s_mag, s_den;
    logic        s_neg, s_zero, s_full;

    // Range check and quotient step
    logic [29:0] s_num;
    logic        s_ovf;
    logic [15:0] s_trial, s_diff;
    logic        s_ge;

    // Control strobes
    logic        s_accept, s_lane_done, s_load_out;
    logic        s_wr_en, s_div_start;
    logic [14:0] s_wr_q;

    assign s_sample = r_timer[17] || (r_timer == '0);
    assign s_tdec   = {r_timer[17], r_timer} - {3'b000, i_elapsed_ms};
    // The countdown saturates at the most negative timer value.
    assign s_timer_dec = (s_tdec[18] && !s_tdec[17]) ? gic_pkg::TIMER_MIN : s_tdec[17:0];

    always_comb begin
        s_raw   = r_raw_axis[r_lane[1:0]];
        s_mag16 = s_raw[15] ? 16'(-s_raw) : s_raw;
        s_dz    = r_lane[1] ? r_right_dz : r_left_dz;
        s_m16   = (s_mag16 > {1'b0, s_dz}) ? (s_mag16 - {1'b0, s_dz}) : '0;
        s_axis_m = (s_m16 > {1'b0, r_stick_max}) ? r_stick_max : s_m16[14:0];
        s_t     = r_raw_trig[r_lane[0]];
        s_b     = (s_t > r_trig_max) ? r_trig_max : s_t;
        if (r_lane[2]) begin
            s_mag  = {7'b0, 8'(s_b - r_trig_th)};
            s_den  = {7'b0, 8'(r_trig_max - r_trig_th)};
            s_neg  = 1'b0;
            s_zero = (s_b <= r_trig_th);
            s_full = 1'b0;
        end else begin
            s_mag  = s_axis_m;
            s_den  = r_stick_max - s_dz;
            s_neg  = s_raw[15];
            s_zero = (s_axis_m == '0);
            s_full = (r_stick_max <= s_dz);
        end
    end

    // mag * 32767 as a shift and subtract; a quotient of 32768 or more saturates.
    assign s_num   = {r_mag, 15'b0} - {15'b0, r_mag};
    assign s_ovf   = (s_num >= {r_den, 15'b0});
    assign s_trial = {r_rem, r_low[14]};
    assign s_ge    = (s_trial >= {1'b0, r_den});
    assign s_diff  = s_trial - {1'b0, r_den};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gic_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (s_sample && i_read_ok) ? gic_pkg::ST_SETUP : gic_pkg::ST_OUT;
                end
            end
            gic_pkg::ST_SETUP: begin
                n_state = gic_pkg::ST_CHECK;
            end
            gic_pkg::ST_CHECK: begin
                if (r_zero || r_full || s_ovf) begin
                    n_state = (r_lane == gic_pkg::LANE_LAST) ? gic_pkg::ST_OUT
                                                             : gic_pkg::ST_SETUP;
                end else begin
                    n_state = gic_pkg::ST_DIV;
                end
            end
            gic_pkg::ST_DIV: begin
                if (r_cnt == gic_pkg::DIV_LAST) begin
                    n_state = (r_lane == gic_pkg::LANE_LAST) ? gic_pkg::ST_OUT
                                                             : gic_pkg::ST_SETUP;
                end
            end
            gic_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = gic_pkg::ST_IDLE;
                end
            end
            default: n_state = gic_pkg::ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        s_accept    = 1'b0;
        s_wr_en     = 1'b0;
        s_wr_q      = '0;
        s_div_start = 1'b0;
        s_load_out  = 1'b0;
        unique case (r_state)
            gic_pkg::ST_IDLE: begin
                s_accept = i_in_valid;
            end
            gic_pkg::ST_SETUP: begin
            end
            gic_pkg::ST_CHECK: begin
                if (r_zero) begin
                    s_wr_en = 1'b1;
                end else if (r_full || s_ovf) begin
                    s_wr_en = 1'b1;
                    s_wr_q  = gic_pkg::FULL_SCALE;
                end else begin
                    s_div_start = 1'b1;
                end
            end
            gic_pkg::ST_DIV: begin
                if (r_cnt == gic_pkg::DIV_LAST) begin
                    s_wr_en = 1'b1;
                    s_wr_q  = {r_low[13:0], s_ge};
                end
            end
            gic_pkg::ST_OUT: begin
                s_load_out = !r_out_valid || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    assign s_lane_done = s_wr_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz   <= gic_pkg::RST_LEFT_DZ;
            r_right_dz  <= gic_pkg::RST_RIGHT_DZ;
            r_stick_max <= gic_pkg::RST_STICK_MAX;
            r_trig_th   <= gic_pkg::RST_TRIG_TH;
            r_trig_max  <= gic_pkg::RST_TRIG_MAX;
            r_retry_ms  <= gic_pkg::RST_RETRY_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gic_pkg::CFG_LEFT_DZ:   r_left_dz   <= i_cfg_data[14:0];
                gic_pkg::CFG_RIGHT_DZ:  r_right_dz  <= i_cfg_data[14:0];
                gic_pkg::CFG_STICK_MAX: r_stick_max <= i_cfg_data[14:0];
                gic_pkg::CFG_TRIG_TH:   r_trig_th   <= i_cfg_data[7:0];
                gic_pkg::CFG_TRIG_MAX:  r_trig_max  <= i_cfg_data[7:0];
                gic_pkg::CFG_RETRY_MS:  r_retry_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, timer and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gic_pkg::ST_IDLE;
            r_timer    <= '0;
            r_buttons  <= '0;
            r_pressed  <= '0;
            r_released <= '0;
            r_sampled  <= 1'b0;
            r_lane     <= '0;
            r_cnt      <= '0;
            for (int i = 0; i < 4; i++) begin
                r_axis[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_trig[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (s_accept) begin
                r_sampled <= s_sample && i_read_ok;
                r_lane    <= '0;
                if (s_sample) begin
                    if (i_read_ok) begin
                        r_timer    <= '0;
                        r_pressed  <= (r_buttons ^ i_raw_buttons) & i_raw_buttons;
                        r_released <= (r_buttons ^ i_raw_buttons) & r_buttons;
                        r_buttons  <= i_raw_buttons;
                    end else begin
                        r_timer <= {2'b00, r_retry_ms};
                    end
                end else begin
                    r_timer <= s_timer_dec;
                end
            end
            if (s_div_start) begin
                r_cnt <= '0;
            end else if (r_state == gic_pkg::ST_DIV) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (s_lane_done) begin
                r_lane <= r_lane + 3'd1;
                if (r_lane[2]) begin
                    r_trig[r_lane[0]] <= s_wr_q;
                end else begin
                    r_axis[r_lane[1:0]] <= r_neg ? 16'(-{1'b0, s_wr_q}) : {1'b0, s_wr_q};
                end
            end
        end
    end

    // Lane operands and divider datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_raw_axis[0] <= i_raw_left_x;
            r_raw_axis[1] <= i_raw_left_y;
            r_raw_axis[2] <= i_raw_right_x;
            r_raw_axis[3] <= i_raw_right_y;
            r_raw_trig[0] <= i_raw_left_trigger;
            r_raw_trig[1] <= i_raw_right_trigger;
        end
        if (r_state == gic_pkg::ST_SETUP) begin
            r_mag  <= s_mag;
            r_den  <= s_den;
            r_neg  <= s_neg;
            r_zero <= s_zero;
            r_full <= s_full;
        end
        if (s_div_start) begin
            // The top half is below the divisor, so 15 quotient bits suffice.
            r_rem <= s_num[29:15];
            r_low <= s_num[14:0];
        end else if (r_state == gic_pkg::ST_DIV) begin
            r_rem <= s_ge ? s_diff[14:0] : s_trial[14:0];
            r_low <= {r_low[13:0], s_ge};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out_sampled  <= r_sampled;
            r_out_buttons  <= r_buttons;
            r_out_pressed  <= r_pressed;
            r_out_released <= r_released;
            for (int i = 0; i < 4; i++) begin
                r_out_axis[i] <= r_axis[i];
            end
            for (int i = 0; i < 2; i++) begin
                r_out_trig[i] <= r_trig[i];
            end
        end
    end

    assign o_in_ready              = (r_state == gic_pkg::ST_IDLE);
    assign o_out_valid             = r_out_valid;
    assign o_sampled               = r_out_sampled;
    assign o_buttons_down          = r_out_buttons;
    assign o_buttons_pressed_edge  = r_out_pressed;
    assign o_buttons_released_edge = r_out_released;
    assign o_left_x                = r_out_axis[0];
    assign o_left_y                = r_out_axis[1];
    assign o_right_x               = r_out_axis[2];
    assign o_right_y               = r_out_axis[3];
    assign o_left_trigger          = r_out_trig[0];
    assign o_right_trigger         = r_out_trig[1];

endmodule

// ----- rtl/gic_checker.sv -----
// Port-level checks for the gamepad input conditioner, bound to the top level.
// Depends only on the top level's ports.
module gic_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_left_x,
    input logic signed [15:0] o_left_y,
    input logic signed [15:0] o_right_x,
    input logic signed [15:0] o_right_y
);

    // A held result stays offered until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_left_x) && $stable(o_left_y)
            && $stable(o_right_x) && $stable(o_right_y))
        else $error("stalled result changed");

    // The block is ready for an item in the cycle after reset.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("not ready after reset");

    // One item at a time: an input transfer closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // Stick outputs are symmetric and never reach the most negative code.
    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_x != 16'sh8000 && o_left_y != 16'sh8000
            && o_right_x != 16'sh8000 && o_right_y != 16'sh8000)
        else $error("stick output out of range");

endmodule

bind gamepad_input_conditioner_unit gic_checker u_gic_checker (.*);

// ----- test/gamepad_conditioner_checker.sv -----
`timescale 1ns / 1ps
// Checker for the gamepad input conditioner. It watches the register port and both channels,
// predicts every result and compares it field by field with what the block hands out.
// Depends on gic_pkg for the register indexes, reset values and full-scale constant.
module gamepad_conditioner_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_elapsed_ms,
    input  logic               i_read_ok,
    input  logic [15:0]        i_raw_buttons,
    input  logic signed [15:0] i_raw_left_x,
    input  logic signed [15:0] i_raw_left_y,
    input  logic signed [15:0] i_raw_right_x,
    input  logic signed [15:0] i_raw_right_y,
    input  logic [7:0]         i_raw_left_trigger,
    input  logic [7:0]         i_raw_right_trigger,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_sampled,
    input  logic [15:0]        i_buttons_down,
    input  logic [15:0]        i_buttons_pressed_edge,
    input  logic [15:0]        i_buttons_released_edge,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [14:0]        i_left_trigger,
    input  logic [14:0]        i_right_trigger,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_fresh
);

    localparam int FULL_Q      = gic_pkg::FULL_SCALE;
    localparam int TIMER_FLOOR = -131072;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        logic             sampled;
        logic [15:0]      down;
        logic [15:0]      pressed;
        logic [15:0]      released;
        logic [3:0][15:0] axes;
        logic [1:0][14:0] triggers;
    } t_pad_report;

    t_pad_report pad_reports_due[$];
    t_pad_report held;

    logic [14:0] left_dz;
    logic [14:0] right_dz;
    logic [14:0] stick_full;
    logic [7:0]  trig_floor;
    logic [7:0]  trig_full;
    logic [15:0] retry_wait;
    int          retry_timer;

    int fail_total    = 0;
    int checked_total = 0;
    int fresh_total   = 0;

    task automatic report_mismatch(input string msg);
        fail_total++;
        if (fail_total <= PRINT_LIMIT) begin
            $display("MISMATCH result %0d: %s", checked_total, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    // Axial dead zone: magnitude past the dead zone, clamped, scaled to Q1.15 with the sign kept.
    function automatic logic [15:0] scale_stick(input logic [15:0] raw, input logic [14:0] dz);
        int v;
        int mag;
        int dzi;
        int mxi;
        int q;
        int s;
        v   = $signed(raw);
        dzi = dz;
        mxi = stick_full;
        mag = (v < 0) ? -v : v;
        mag = (mag <= dzi) ? 0 : mag - dzi;
        if (mag > mxi) mag = mxi;
        if (mag == 0) return 16'd0;
        if (mxi <= dzi) begin
            q = FULL_Q;
        end else begin
            q = (mag * FULL_Q) / (mxi - dzi);
            if (q > FULL_Q) q = FULL_Q;
        end
        s = (v < 0) ? -q : q;
        return s[15:0];
    endfunction

    function automatic logic [14:0] scale_trigger(input logic [7:0] raw);
        int b;
        int thi;
        int mxi;
        int q;
        b   = raw;
        thi = trig_floor;
        mxi = trig_full;
        if (b > mxi) b = mxi;
        if (b <= thi) return 15'd0;
        q = ((b - thi) * FULL_Q) / (mxi - thi);
        if (q > FULL_Q) q = FULL_Q;
        return q[14:0];
    endfunction

    task automatic condition_poll(output t_pad_report rpt);
        logic [15:0] diff;
        logic        fresh;
        int          el;
        int          t;
        fresh = 1'b0;
        if (retry_timer <= 0) begin
            if (i_read_ok) begin
                diff              = held.down ^ i_raw_buttons;
                held.pressed      = diff & i_raw_buttons;
                held.released     = diff & held.down;
                held.down         = i_raw_buttons;
                held.axes[0]      = scale_stick(i_raw_left_x, left_dz);
                held.axes[1]      = scale_stick(i_raw_left_y, left_dz);
                held.axes[2]      = scale_stick(i_raw_right_x, right_dz);
                held.axes[3]      = scale_stick(i_raw_right_y, right_dz);
                held.triggers[0]  = scale_trigger(i_raw_left_trigger);
                held.triggers[1]  = scale_trigger(i_raw_right_trigger);
                retry_timer       = 0;
                fresh             = 1'b1;
            end else begin
                retry_timer = retry_wait;
            end
        end else begin
            el = i_elapsed_ms;
            t  = retry_timer - el;
            retry_timer = (t < TIMER_FLOOR) ? TIMER_FLOOR : t;
        end
        rpt         = held;
        rpt.sampled = fresh;
    endtask

    always @(posedge i_clk) begin : watch
        t_pad_report due;
        if (!i_rst_n) begin
            left_dz     = gic_pkg::RST_LEFT_DZ;
            right_dz    = gic_pkg::RST_RIGHT_DZ;
            stick_full  = gic_pkg::RST_STICK_MAX;
            trig_floor  = gic_pkg::RST_TRIG_TH;
            trig_full   = gic_pkg::RST_TRIG_MAX;
            retry_wait  = gic_pkg::RST_RETRY_MS;
            retry_timer = 0;
            held        = '0;
            pad_reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gic_pkg::CFG_LEFT_DZ:   left_dz    = i_cfg_data[14:0];
                    gic_pkg::CFG_RIGHT_DZ:  right_dz   = i_cfg_data[14:0];
                    gic_pkg::CFG_STICK_MAX: stick_full = i_cfg_data[14:0];
                    gic_pkg::CFG_TRIG_TH:   trig_floor = i_cfg_data[7:0];
                    gic_pkg::CFG_TRIG_MAX:  trig_full  = i_cfg_data[7:0];
                    gic_pkg::CFG_RETRY_MS:  retry_wait = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                condition_poll(due);
                if (due.sampled) fresh_total++;
                pad_reports_due.push_back(due);
            end
            if (i_out_valid && i_out_ready) begin
                checked_total++;
                if (pad_reports_due.size() == 0) begin
                    report_mismatch("result transfer with no poll outstanding");
                end else begin
                    due = pad_reports_due.pop_front();
                    check_field("sampled", 16'(i_sampled), 16'(due.sampled));
                    check_field("buttons_down", i_buttons_down, due.down);
                    check_field("buttons_pressed_edge", i_buttons_pressed_edge, due.pressed);
                    check_field("buttons_released_edge", i_buttons_released_edge, due.released);
                    check_field("left_x", i_left_x, due.axes[0]);
                    check_field("left_y", i_left_y, due.axes[1]);
                    check_field("right_x", i_right_x, due.axes[2]);
                    check_field("right_y", i_right_y, due.axes[3]);
                    check_field("left_trigger", 16'(i_left_trigger), 16'(due.triggers[0]));
                    check_field("right_trigger", 16'(i_right_trigger), 16'(due.triggers[1]));
                end
            end
        end
        o_pending    <= pad_reports_due.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_fresh      <= fresh_total;
    end

endmodule

// ----- test/gamepad_input_conditioner_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the gamepad input conditioner: clock, reset, register programming,
// poll stimulus and output back-pressure. Depends on gic_pkg, the block and the checker.
module gamepad_input_conditioner_unit_test;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         END_WAIT    = 20;
    localparam int         SETTLE      = 4;
    localparam int         PHASES      = 10;
    localparam int         PHASE_POLLS = 104;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [15:0]        i_elapsed_ms;
    logic               i_read_ok;
    logic [15:0]        i_raw_buttons;
    logic signed [15:0] i_raw_left_x;
    logic signed [15:0] i_raw_left_y;
    logic signed [15:0] i_raw_right_x;
    logic signed [15:0] i_raw_right_y;
    logic [7:0]         i_raw_left_trigger;
    logic [7:0]         i_raw_right_trigger;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_sampled;
    logic [15:0]        o_buttons_down;
    logic [15:0]        o_buttons_pressed_edge;
    logic [15:0]        o_buttons_released_edge;
    logic signed [15:0] o_left_x;
    logic signed [15:0] o_left_y;
    logic signed [15:0] o_right_x;
    logic signed [15:0] o_right_y;
    logic [14:0]        o_left_trigger;
    logic [14:0]        o_right_trigger;

    int fail_count;
    int pending;
    int checked;
    int fresh;

    int          cycle_count = 0;
    int          polls_sent  = 0;
    int          settings    = 0;
    int          hold_asks   = 0;
    int          hold_served = 0;
    int          drains      = 0;
    bit          quiet       = 1'b0;
    int          cfg_ldz;
    int          cfg_rdz;
    int          cfg_smax;
    int          cfg_th;
    int          cfg_tmax;
    int          cfg_retry;
    logic [15:0] last_buttons = '0;

    gamepad_input_conditioner_unit u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_elapsed_ms            (i_elapsed_ms),
        .i_read_ok               (i_read_ok),
        .i_raw_buttons           (i_raw_buttons),
        .i_raw_left_x            (i_raw_left_x),
        .i_raw_left_y            (i_raw_left_y),
        .i_raw_right_x           (i_raw_right_x),
        .i_raw_right_y           (i_raw_right_y),
        .i_raw_left_trigger      (i_raw_left_trigger),
        .i_raw_right_trigger     (i_raw_right_trigger),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_sampled               (o_sampled),
        .o_buttons_down          (o_buttons_down),
        .o_buttons_pressed_edge  (o_buttons_pressed_edge),
        .o_buttons_released_edge (o_buttons_released_edge),
        .o_left_x                (o_left_x),
        .o_left_y                (o_left_y),
        .o_right_x               (o_right_x),
        .o_right_y               (o_right_y),
        .o_left_trigger          (o_left_trigger),
        .o_right_trigger         (o_right_trigger)
    );

    gamepad_conditioner_checker u_checker (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .i_in_ready              (o_in_ready),
        .i_elapsed_ms            (i_elapsed_ms),
        .i_read_ok               (i_read_ok),
        .i_raw_buttons           (i_raw_buttons),
        .i_raw_left_x            (i_raw_left_x),
        .i_raw_left_y            (i_raw_left_y),
        .i_raw_right_x           (i_raw_right_x),
        .i_raw_right_y           (i_raw_right_y),
        .i_raw_left_trigger      (i_raw_left_trigger),
        .i_raw_right_trigger     (i_raw_right_trigger),
        .i_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .i_sampled               (o_sampled),
        .i_buttons_down          (o_buttons_down),
        .i_buttons_pressed_edge  (o_buttons_pressed_edge),
        .i_buttons_released_edge (o_buttons_released_edge),
        .i_left_x                (o_left_x),
        .i_left_y                (o_left_y),
        .i_right_x               (o_right_x),
        .i_right_y               (o_right_y),
        .i_left_trigger          (o_left_trigger),
        .i_right_trigger         (o_right_trigger),
        .o_fail_count            (fail_count),
        .o_pending               (pending),
        .o_checked               (checked),
        .o_fresh                 (fresh)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("gamepad_input_conditioner_unit_test failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request so the block backs up.
    initial begin
        int hold_count;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_served != hold_asks) begin
                i_out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge i_clk);
                hold_served++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Valid stays high after a transfer unless a random gap drops it; the caller either
    // sends again in the same step or lowers it before letting time pass.
    task automatic send_poll(input logic [15:0] elapsed, input logic ok,
                             input logic [15:0] buttons,
                             input logic [15:0] lx, input logic [15:0] ly,
                             input logic [15:0] rx, input logic [15:0] ry,
                             input logic [7:0] lt, input logic [7:0] rt);
        i_in_valid          <= 1'b1;
        i_elapsed_ms        <= elapsed;
        i_read_ok           <= ok;
        i_raw_buttons       <= buttons;
        i_raw_left_x        <= lx;
        i_raw_left_y        <= ly;
        i_raw_right_x       <= rx;
        i_raw_right_y       <= ry;
        i_raw_left_trigger  <= lt;
        i_raw_right_trigger <= rt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        polls_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_regs(input int ldz, input int rdz, input int smax,
                                input int th, input int tmax, input int retry);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gic_pkg::CFG_LEFT_DZ;
        i_cfg_data  <= 16'(ldz);
        @(posedge i_clk);
        i_cfg_index <= gic_pkg::CFG_RIGHT_DZ;
        i_cfg_data  <= 16'(rdz);
        @(posedge i_clk);
        i_cfg_index <= gic_pkg::CFG_STICK_MAX;
        i_cfg_data  <= 16'(smax);
        @(posedge i_clk);
        i_cfg_index <= gic_pkg::CFG_TRIG_TH;
        i_cfg_data  <= 16'(th);
        @(posedge i_clk);
        i_cfg_index <= gic_pkg::CFG_TRIG_MAX;
        i_cfg_data  <= 16'(tmax);
        @(posedge i_clk);
        i_cfg_index <= gic_pkg::CFG_RETRY_MS;
        i_cfg_data  <= 16'(retry);
        @(posedge i_clk);
        // A write to an index with no register behind it must change nothing.
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_ldz   = ldz;
        cfg_rdz   = rdz;
        cfg_smax  = smax;
        cfg_th    = th;
        cfg_tmax  = tmax;
        cfg_retry = retry;
        settings++;
    endtask

    // Stick samples cluster around the dead-zone edge and the saturation point.
    function automatic logic [15:0] pick_axis(input int dz);
        int   mag;
        int   offset;
        logic negative;
        negative = 1'($urandom_range(0, 1));
        offset   = $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: mag = dz + offset - 3;
            2: mag = dz + cfg_smax + offset - 3;
            3: mag = 32768;
            4: mag = offset;
            default: mag = $urandom_range(0, 32767);
        endcase
        if (mag < 0) mag = 0;
        if (mag > 32768) mag = 32768;
        if (!negative && mag > 32767) mag = 32767;
        mag = negative ? -mag : mag;
        return mag[15:0];
    endfunction

    function automatic logic [7:0] pick_trigger();
        int level;
        int offset;
        offset = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
            0: level = $urandom_range(0, 255);
            1: level = cfg_th + offset - 2;
            2: level = cfg_tmax + offset - 2;
            default: level = $urandom_range(0, 1) ? 255 : 0;
        endcase
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        return level[7:0];
    endfunction

    task automatic send_random_poll();
        logic [15:0] elapsed;
        logic [15:0] buttons;
        case ($urandom_range(0, 3))
            0: elapsed = 16'($urandom_range(0, 20));
            1: elapsed = 16'($urandom_range(0, cfg_retry + 1));
            2: elapsed = 16'($urandom);
            default: elapsed = 16'($urandom_range(0, 500));
        endcase
        // Mostly single-button changes so the edge bitmaps stay sparse.
        if ($urandom_range(0, 2) == 0) begin
            buttons = 16'($urandom);
        end else begin
            buttons = last_buttons ^ (16'd1 << $urandom_range(0, 15));
        end
        last_buttons = buttons;
        send_poll(elapsed, $urandom_range(0, 7) != 0, buttons,
                  pick_axis(cfg_ldz), pick_axis(cfg_ldz),
                  pick_axis(cfg_rdz), pick_axis(cfg_rdz),
                  pick_trigger(), pick_trigger());
    endtask

    initial begin
        int phase;
        int n;
        int ldz;
        int rdz;
        int th;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_index         <= gic_pkg::CFG_LEFT_DZ;
        i_cfg_data          <= '0;
        i_in_valid          <= 1'b0;
        i_elapsed_ms        <= '0;
        i_read_ok           <= 1'b0;
        i_raw_buttons       <= '0;
        i_raw_left_x        <= '0;
        i_raw_left_y        <= '0;
        i_raw_right_x       <= '0;
        i_raw_right_y       <= '0;
        i_raw_left_trigger  <= '0;
        i_raw_right_trigger <= '0;
        cfg_ldz   = gic_pkg::RST_LEFT_DZ;
        cfg_rdz   = gic_pkg::RST_RIGHT_DZ;
        cfg_smax  = gic_pkg::RST_STICK_MAX;
        cfg_th    = gic_pkg::RST_TRIG_TH;
        cfg_tmax  = gic_pkg::RST_TRIG_MAX;
        cfg_retry = gic_pkg::RST_RETRY_MS;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: field extremes, dead-zone and threshold edges, retry countdown.
        send_poll(16'd0, 1'b1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 8'd255, 8'd0);
        send_poll(16'd65535, 1'b1, 16'h0000, 16'd7849, -16'sd7850, 16'd8689, -16'sd8690,
                  8'd30, 8'd31);
        send_poll(16'd3, 1'b1, 16'hA5A5, 16'd16000, -16'sd16000, 16'd32767, -16'sd32767,
                  8'd250, 8'd251);
        send_poll(16'd7, 1'b1, 16'h5A5A, 16'd7850, 16'h8000, -16'sd8689, 16'd8690,
                  8'd31, 8'd249);
        send_poll(16'd10, 1'b0, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4, 8'd5, 8'd6);
        send_poll(16'd1999, 1'b1, 16'h1234, 16'd30000, 16'd30000, 16'd30000, 16'd30000,
                  8'd200, 8'd200);
        send_poll(16'd1, 1'b1, 16'h4321, 16'd30000, 16'd30000, 16'd30000, 16'd30000,
                  8'd200, 8'd200);
        send_poll(16'd0, 1'b1, 16'h0F0F, 16'd20000, -16'sd20000, 16'd20000, -16'sd20000,
                  8'd100, 8'd200);
        send_poll(16'd65535, 1'b0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_poll(16'd65535, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_poll(16'd0, 1'b1, 16'hF0F0, -16'sd12345, 16'd12345, 16'd9000, -16'sd9000,
                  8'd128, 8'd64);

        // Dead zones at or above stick_max, threshold above trigger_max, zero retry wait.
        program_regs(32766, 1, 1, 254, 1, 0);
        send_poll(16'd0, 1'b1, 16'hFFFF, 16'h7FFF, -16'sd32767, 16'd2, 16'hFFFF, 8'd255, 8'd0);
        send_poll(16'd0, 1'b0, 16'h0000, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_poll(16'd0, 1'b1, 16'h0000, 16'h8000, 16'd32766, -16'sd2, 16'd1, 8'd254, 8'd1);
        send_poll(16'd40000, 1'b0, 16'hFFFF, 16'd5, 16'd5, 16'd5, 16'd5, 8'd5, 8'd5);
        send_poll(16'd0, 1'b1, 16'h8001, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 8'd255, 8'd255);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs(gic_pkg::RST_LEFT_DZ, gic_pkg::RST_RIGHT_DZ,
                                gic_pkg::RST_STICK_MAX, gic_pkg::RST_TRIG_TH,
                                gic_pkg::RST_TRIG_MAX, gic_pkg::RST_RETRY_MS);
                1: program_regs(0, 0, 32767, 0, 255, 0);
                2: program_regs(32766, 32765, 32767, 254, 255, 65535);
                3: program_regs($urandom_range(0, 80), $urandom_range(0, 80),
                                $urandom_range(1, 60), $urandom_range(0, 254),
                                $urandom_range(1, 255), $urandom_range(0, 40));
                default: begin
                    ldz = $urandom_range(0, 12000);
                    rdz = $urandom_range(0, 12000);
                    th  = $urandom_range(0, 200);
                    program_regs(ldz, rdz, $urandom_range(12001, 32767), th,
                                 $urandom_range(th + 1, 255), $urandom_range(0, 3000));
                end
            endcase
            if (phase == PHASES - 1) quiet = 1'b1;
            for (n = 0; n < PHASE_POLLS; n++) begin
                if (phase == 2 && n == 20) hold_asks++;
                if (phase == 5 && n == 50) begin
                    wait_idle();
                    drains++;
                end
                send_random_poll();
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        $display("Summary: %0d polls over %0d register settings, %0d results checked, %0d fresh.",
                 polls_sent, settings, checked, fresh);
        $display("Summary: %0d long output hold-offs, %0d full drains, %0d cycles.",
                 hold_served, drains, cycle_count);
        if (fail_count == 0) begin
            $display("gamepad_input_conditioner_unit_test passed");
        end else begin
            $display("gamepad_input_conditioner_unit_test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gic_pkg.sv
rtl/gamepad_input_conditioner_unit.sv
rtl/gic_checker.sv
test/gamepad_conditioner_checker.sv
test/gamepad_input_conditioner_unit_test.sv
